@@ rtl/core/btnar_pkg.sv @@
// shared types and constants for the button edge and auto-repeat block
`default_nettype none

package btnar_pkg;

  // number of physical buttons (1 to 64); only the first 32 are visible
  localparam int unsigned BTN_COUNT  = 32;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned LANE_COUNT = (BTN_COUNT < MASK_W) ? BTN_COUNT : MASK_W;

  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // buttons that exist inside the visible mask
  localparam logic [MASK_W-1:0] ACTIVE_MASK = (BTN_COUNT >= MASK_W) ? '1 :
      MASK_W'((64'd1 << BTN_COUNT) - 64'd1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD  = 2'd3;

  // reset values
  localparam logic [CFG_W-1:0] HOLD_DELAY_RST   = 8'd7;
  localparam logic [CFG_W-1:0] REPEAT_START_RST = 8'd25;
  localparam logic [CFG_W-1:0] FAST_PERIOD_RST  = 8'd8;
  localparam logic [CFG_W-1:0] SLOW_PERIOD_RST  = 8'd12;

  typedef struct packed {
    logic [CFG_W-1:0] hold_delay;
    logic [CFG_W-1:0] repeat_start;
    logic [CFG_W-1:0] fast_period;
    logic [CFG_W-1:0] slow_period;
  } btnar_cfg_t;

  typedef struct packed {
    logic held;
    logic fast_rpt;
    logic slow_rpt;
  } btnar_lane_t;

endpackage

`default_nettype wire

@@ rtl/core/button_edge_and_autorepeat.sv @@
// top level: button edge detect, hold and auto-repeat per frame beat
//
// Usage: each input beat on in_* carries one frame's vector of pressed
// buttons (bit i high means button i is down). For every input beat the
// block returns one result beat on out_*: pressed and released edges
// against the previous frame, the held mask and fast and slow auto-repeat
// pulse masks.
// The result register is loaded at the edge that accepts the input beat.
// Throughput is one beat per cycle unless the receiver stalls; the per-button
// counters update in parallel, so the result register is the only stage.
// A new beat is taken while the current result is being drained, so a
// receiver that takes every cycle sees no bubble. When the receiver stalls,
// the result holds and in_ready_o drops until the result is taken.
// Reset clears the previous-frame vector and all counters and loads the
// register defaults: hold delay 7, repeat start 25, fast period 8, slow
// period 12. Configuration writes on cfg_* take effect at the next edge. The
// user must make them only while no beat is in flight; the block has no check.
`default_nettype none

module button_edge_and_autorepeat (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [btnar_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [btnar_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [btnar_pkg::MASK_W-1:0]    buttons_now_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [btnar_pkg::MASK_W-1:0]         pressed_mask_o,
  output logic [btnar_pkg::MASK_W-1:0]         released_mask_o,
  output logic [btnar_pkg::MASK_W-1:0]         held_mask_o,
  output logic [btnar_pkg::MASK_W-1:0]         fast_repeat_mask_o,
  output logic [btnar_pkg::MASK_W-1:0]         slow_repeat_mask_o
);
  import btnar_pkg::*;

  btnar_cfg_t        cfg;
  logic              step;
  logic              out_valid_q;
  logic [MASK_W-1:0] now;
  logic [MASK_W-1:0] last_q;
  logic [MASK_W-1:0] held_w, fast_w, slow_w;
  logic [MASK_W-1:0] pressed_q, released_q, held_q, fast_q, slow_q;

  // handshake: accept when the result slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;
  assign now        = buttons_now_i & ACTIVE_MASK;

  btnar_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // one lane per visible button, zero for bits beyond the button count
  for (genvar i = 0; i < MASK_W; i++) begin : g_lane
    if (i < LANE_COUNT) begin : g_on
      btnar_lane_t stat;
      btnar_lane u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .step_i (step),
        .down_i (now[i]),
        .cfg_i  (cfg),
        .stat_o (stat)
      );
      assign held_w[i] = stat.held;
      assign fast_w[i] = stat.fast_rpt;
      assign slow_w[i] = stat.slow_rpt;
    end else begin : g_off
      assign held_w[i] = 1'b0;
      assign fast_w[i] = 1'b0;
      assign slow_w[i] = 1'b0;
    end
  end

  // control state: previous frame and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        last_q <= now;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      pressed_q  <= now & ~last_q;
      released_q <= ~now & last_q;
      held_q     <= held_w;
      fast_q     <= fast_w;
      slow_q     <= slow_w;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pressed_mask_o     = pressed_q;
  assign released_mask_o    = released_q;
  assign held_mask_o        = held_q;
  assign fast_repeat_mask_o = fast_q;
  assign slow_repeat_mask_o = slow_q;

endmodule

`default_nettype wire

@@ rtl/core/btnar_cfg_regs.sv @@
// configuration register file for hold delay, repeat start and periods
`default_nettype none

module btnar_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [btnar_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [btnar_pkg::CFG_W-1:0]     cfg_wdata_i,
  output btnar_pkg::btnar_cfg_t                cfg_o
);
  import btnar_pkg::*;

  btnar_cfg_t cfg_q, cfg_d;

  // decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HOLD_DELAY:   cfg_d.hold_delay   = cfg_wdata_i;
        CFG_REPEAT_START: cfg_d.repeat_start = cfg_wdata_i;
        CFG_FAST_PERIOD:  cfg_d.fast_period  = cfg_wdata_i;
        CFG_SLOW_PERIOD:  cfg_d.slow_period  = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_delay   <= HOLD_DELAY_RST;
      cfg_q.repeat_start <= REPEAT_START_RST;
      cfg_q.fast_period  <= FAST_PERIOD_RST;
      cfg_q.slow_period  <= SLOW_PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/btnar_lane.sv @@
// one button: fast and slow frame counters with hold and repeat decisions
`default_nettype none

module btnar_lane (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  down_i,
  input  wire btnar_pkg::btnar_cfg_t cfg_i,
  output btnar_pkg::btnar_lane_t     stat_o
);
  import btnar_pkg::*;

  logic [CNT_W-1:0] fast_q, fast_d;
  logic [CNT_W-1:0] slow_q, slow_d;
  logic [CNT_W-1:0] fast_inc, slow_inc;
  logic             fast_hit, slow_hit;

  // saturating increment, then threshold tests on the new value
  assign fast_inc = (fast_q == '1) ? fast_q : fast_q + CNT_W'(1);
  assign slow_inc = (slow_q == '1) ? slow_q : slow_q + CNT_W'(1);
  assign fast_hit = fast_inc > cfg_i.repeat_start;
  assign slow_hit = slow_inc > cfg_i.repeat_start;

  // period drop after a pulse, floored at zero; cleared while up
  always_comb begin
    fast_d = fast_inc;
    slow_d = slow_inc;
    if (fast_hit) begin
      fast_d = (fast_inc > cfg_i.fast_period) ? fast_inc - cfg_i.fast_period : '0;
    end
    if (slow_hit) begin
      slow_d = (slow_inc > cfg_i.slow_period) ? slow_inc - cfg_i.slow_period : '0;
    end
    if (!down_i) begin
      fast_d = '0;
      slow_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
    end else if (step_i) begin
      fast_q <= fast_d;
      slow_q <= slow_d;
    end
  end

  assign stat_o.held     = down_i & (fast_inc > cfg_i.hold_delay);
  assign stat_o.fast_rpt = down_i & fast_hit;
  assign stat_o.slow_rpt = down_i & slow_hit;

endmodule

`default_nettype wire

@@ tb/button_edge_and_autorepeat_tb.sv @@
// self-checking bench for the button edge, hold and auto-repeat block
module button_edge_and_autorepeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btnar_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 7;

  typedef struct packed {
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] released;
    logic [MASK_W-1:0] held;
    logic [MASK_W-1:0] fast;
    logic [MASK_W-1:0] slow;
  } frame_result_t;

  typedef struct {
    logic [CFG_W-1:0] hold_delay;
    logic [CFG_W-1:0] repeat_start;
    logic [CFG_W-1:0] fast_period;
    logic [CFG_W-1:0] slow_period;
    int unsigned      frames;
    bit               long_hold;
  } phase_plan_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MASK_W-1:0]    buttons_now = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [MASK_W-1:0]    pressed_mask;
  logic [MASK_W-1:0]    released_mask;
  logic [MASK_W-1:0]    held_mask;
  logic [MASK_W-1:0]    fast_repeat_mask;
  logic [MASK_W-1:0]    slow_repeat_mask;

  // frames waiting to be sent and frame results waiting to arrive
  logic [MASK_W-1:0] frame_q[$];
  frame_result_t     frame_result_q[$];

  // mirror of the block state and its registers
  btnar_cfg_t        cfg_model;
  logic [CNT_W-1:0]  fast_cnt[LANE_COUNT];
  logic [CNT_W-1:0]  slow_cnt[LANE_COUNT];
  logic [MASK_W-1:0] prev_frame;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  button_edge_and_autorepeat u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .buttons_now_i      (buttons_now),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .pressed_mask_o     (pressed_mask),
    .released_mask_o    (released_mask),
    .held_mask_o        (held_mask),
    .fast_repeat_mask_o (fast_repeat_mask),
    .slow_repeat_mask_o (slow_repeat_mask)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // one frame through the mirrored counters: increment, hold test, repeat test, period drop
  function automatic frame_result_t advance_counters(logic [MASK_W-1:0] frame);
    frame_result_t     res;
    logic [MASK_W-1:0] now;
    now = frame & ACTIVE_MASK;
    res = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      if (!now[i]) begin
        fast_cnt[i] = '0;
        slow_cnt[i] = '0;
      end else begin
        if (fast_cnt[i] != '1) fast_cnt[i] = fast_cnt[i] + 1'b1;
        if (slow_cnt[i] != '1) slow_cnt[i] = slow_cnt[i] + 1'b1;
        if (fast_cnt[i] > cfg_model.hold_delay) res.held[i] = 1'b1;
        if (fast_cnt[i] > cfg_model.repeat_start) begin
          res.fast[i] = 1'b1;
          fast_cnt[i] = (fast_cnt[i] > cfg_model.fast_period) ?
              fast_cnt[i] - cfg_model.fast_period : '0;
        end
        if (slow_cnt[i] > cfg_model.repeat_start) begin
          res.slow[i] = 1'b1;
          slow_cnt[i] = (slow_cnt[i] > cfg_model.slow_period) ?
              slow_cnt[i] - cfg_model.slow_period : '0;
        end
      end
    end
    res.pressed  = now & ~prev_frame;
    res.released = prev_frame & ~now;
    prev_frame   = now;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [MASK_W-1:0] got,
                                 logic [MASK_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %08h want %08h", cycle_count, field, got, want);
    error_count++;
  endtask

  // write all four registers back to back while the block is idle
  task automatic load_settings(logic [CFG_W-1:0] hold, logic [CFG_W-1:0] start,
                               logic [CFG_W-1:0] fast_p, logic [CFG_W-1:0] slow_p);
    logic [CFG_W-1:0] vals[4];
    vals = '{hold, start, fast_p, slow_p};
    for (int r = 0; r < 4; r++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_wdata <= vals[r];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_model.hold_delay   = hold;
    cfg_model.repeat_start = start;
    cfg_model.fast_period  = fast_p;
    cfg_model.slow_period  = slow_p;
  endtask

  // wait until every frame is sent and every frame result has arrived
  task automatic drain_frames();
    while (frame_q.size() != 0 || frame_result_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // input side: present the next pending frame, with random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      buttons_now <= '0;
    end else begin
      if (in_valid && in_ready) frame_result_q.push_back(advance_counters(buttons_now));
      if (!in_valid || in_ready) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid    <= 1'b1;
          buttons_now <= frame_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result beat with the oldest expected frame result
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_result_q.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = frame_result_q.pop_front();
        if (pressed_mask !== want.pressed)
          report_mismatch("pressed_mask", pressed_mask, want.pressed);
        if (released_mask !== want.released)
          report_mismatch("released_mask", released_mask, want.released);
        if (held_mask !== want.held)
          report_mismatch("held_mask", held_mask, want.held);
        if (fast_repeat_mask !== want.fast)
          report_mismatch("fast_repeat_mask", fast_repeat_mask, want.fast);
        if (slow_repeat_mask !== want.slow)
          report_mismatch("slow_repeat_mask", slow_repeat_mask, want.slow);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    phase_plan_t       plan[PHASES];
    logic [MASK_W-1:0] base;
    logic [MASK_W-1:0] sticky;
    logic [MASK_W-1:0] frame;

    // defaults, low extremes, high extremes, period above counter,
    // zero fast period, random settings, defaults written back
    plan[0] = '{HOLD_DELAY_RST, REPEAT_START_RST, FAST_PERIOD_RST, SLOW_PERIOD_RST, 110, 1'b0};
    plan[1] = '{8'd0, 8'd0, 8'd1, 8'd1, 150, 1'b0};
    plan[2] = '{8'd254, 8'd254, 8'd255, 8'd255, 350, 1'b1};
    plan[3] = '{8'd5, 8'd12, 8'd200, 8'd3, 150, 1'b0};
    plan[4] = '{8'd10, 8'd20, 8'd0, 8'd5, 300, 1'b1};
    plan[5] = '{CFG_W'($urandom_range(254)), CFG_W'($urandom_range(60)),
                CFG_W'($urandom_range(1, 255)), CFG_W'($urandom_range(1, 255)), 150, 1'b0};
    plan[6] = '{HOLD_DELAY_RST, REPEAT_START_RST, FAST_PERIOD_RST, SLOW_PERIOD_RST, 130, 1'b0};

    cfg_model.hold_delay   = HOLD_DELAY_RST;
    cfg_model.repeat_start = REPEAT_START_RST;
    cfg_model.fast_period  = FAST_PERIOD_RST;
    cfg_model.slow_period  = SLOW_PERIOD_RST;
    prev_frame = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      fast_cnt[i] = '0;
      slow_cnt[i] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    base = '0;
    for (int p = 0; p < PHASES; p++) begin
      // sender idles less first, then receiver less, then nobody idles
      if (p < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 72;
      end else if (p < 5) begin
        send_idle_pct = 72;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p != 0)
        load_settings(plan[p].hold_delay, plan[p].repeat_start,
                      plan[p].fast_period, plan[p].slow_period);
      @(negedge clk);

      // directed edges and full-width patterns under reset settings
      if (p == 0) begin
        frame_q.push_back(32'h0000_0000);
        frame_q.push_back(32'hffff_ffff);
        frame_q.push_back(32'hffff_ffff);
        frame_q.push_back(32'h0000_0000);
        frame_q.push_back(32'haaaa_aaaa);
        frame_q.push_back(32'h5555_5555);
        frame_q.push_back(32'h8000_0001);
        frame_q.push_back(32'h8000_0001);
        frame_q.push_back(32'h0000_0000);
        frame_q.push_back(32'hffff_ffff);
      end

      // mostly slowly changing button sets, some buttons kept down, some noise
      sticky = ($urandom & $urandom) | 32'h0000_0001;
      base   = base | sticky;
      for (int n = 0; n < plan[p].frames; n++) begin
        if (!plan[p].long_hold && $urandom_range(149) == 0) begin
          frame = $urandom;
          base  = frame | sticky;
        end else if ($urandom_range(9) == 0) begin
          frame = $urandom | sticky;
        end else begin
          base ^= ($urandom & $urandom & $urandom & $urandom & $urandom) & ~sticky;
          if ($urandom_range(63) == 0) base = $urandom | sticky;
          frame = base;
        end
        frame_q.push_back(frame);
      end
      drain_frames();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
